### src/rrq_pkg.sv
// ----------------------------------------------------------------------------
// rrq_pkg: shared types for the round-robin queue with expedite
// Id type, opcode codes, sequencer states and the sequencer status bundle.
// ----------------------------------------------------------------------------
package rrq_pkg;

   localparam int ID_W = 7;

   typedef logic [ID_W-1:0] id_type;

   // opcode codes
   localparam logic OP_SERVE    = 1'b0;
   localparam logic OP_EXPEDITE = 1'b1;

   // count loaded at reset, before clamping to the queue capacity
   localparam int COUNT_RESET = 64;

   typedef enum logic [2:0] {
      ST_FILL,
      ST_IDLE,
      ST_FRONT,
      ST_SERVE,
      ST_EXPED,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic   req_ready;
      logic   push;
      id_type data;
   } seq_stat_type;

endpackage

### src/round_robin_queue_with_expedite_unit.sv
// ----------------------------------------------------------------------------
// Serve: front read, backward rotate pass over count cells, emit, then result
// register; the next request is accepted only after the result is pushed, so serves
// do not overlap, and a result beat that is held off delays the next serve.
// Expedite: a forward pass over the cells from the front up to the id; out of range: dropped.
// Each pass walks the order RAM one cell per cycle through its single write port.
// Reset and every count write reload the order in a sweep over count cells, req_ready low.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
// round_robin_queue_with_expedite_unit: circular service order with expedite
// Holds the member count and the result register around the pass sequencer.
// ----------------------------------------------------------------------------
module round_robin_queue_with_expedite_unit #(
   parameter int MAX_MEMBERS = 64
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic            req_opcode,
   input  rrq_pkg::id_type req_member_id,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rrq_pkg::id_type rsp_served_id,
   input  logic            csr_wr_en,
   input  rrq_pkg::id_type csr_wr_data
);

   import rrq_pkg::*;

   localparam int CAP      = (MAX_MEMBERS < 127) ? MAX_MEMBERS : 127;
   localparam int COUNT_RV = (COUNT_RESET < CAP) ? COUNT_RESET : CAP;

   id_type       count_ff, count_in;
   logic         out_valid_ff, out_valid_in;
   id_type       out_data_ff, out_data_in;
   logic         slot_free;
   seq_stat_type seq_stat;

   always_comb begin
      count_in = count_ff;
      if (csr_wr_en) begin
         if (csr_wr_data == '0) begin
            count_in = id_type'(1);
         end else if (csr_wr_data > id_type'(CAP)) begin
            count_in = id_type'(CAP);
         end else begin
            count_in = csr_wr_data;
         end
      end
   end

   assign slot_free = !out_valid_ff || rsp_ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (seq_stat.push) begin
         out_valid_in = 1'b1;
         out_data_in  = seq_stat.data;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= id_type'(COUNT_RV);
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
      out_data_ff <= out_data_in;
   end

   rrq_seq #(
      .MAX_MEMBERS (MAX_MEMBERS)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .reload        (csr_wr_en),
      .count         (count_ff),
      .req_valid     (req_valid),
      .req_opcode    (req_opcode),
      .req_member_id (req_member_id),
      .slot_free     (slot_free),
      .stat          (seq_stat)
   );

   assign req_ready     = seq_stat.req_ready;
   assign rsp_valid     = out_valid_ff;
   assign rsp_served_id = out_data_ff;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != '0 && count_ff <= id_type'(CAP))
      else $error("member count out of range");

   a_serve_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_opcode == OP_SERVE |=> !req_ready)
      else $error("serve beat did not start a pass");

   a_reload_busy: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> !req_ready)
      else $error("count write did not start a reload sweep");

   a_rsp_id_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_served_id != '0 && rsp_served_id <= count_ff)
      else $error("served id outside active range");
`endif

endmodule

### src/rrq_ram.sv
// ----------------------------------------------------------------------------
// rrq_ram: generic simple dual-port RAM
// One write port, one read port, registered read data (old data on collision).
// ----------------------------------------------------------------------------
module rrq_ram #(
   parameter int WIDTH = 7,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/rrq_seq.sv
// ----------------------------------------------------------------------------
// rrq_seq: order store and pass sequencer
// Walks the order cells one per cycle with a carry register: a serve runs a
// backward pass that rotates the front to the back, an expedite runs a
// forward pass that pulls the named id to the front. Also reloads the order.
// ----------------------------------------------------------------------------
module rrq_seq #(
   parameter int MAX_MEMBERS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  reload,
   input  rrq_pkg::id_type       count,
   input  logic                  req_valid,
   input  logic                  req_opcode,
   input  rrq_pkg::id_type       req_member_id,
   input  logic                  slot_free,
   output rrq_pkg::seq_stat_type stat
);

   import rrq_pkg::*;

   localparam int AW = $clog2(MAX_MEMBERS);

   typedef logic [AW-1:0] addr_type;

   state_type state_ff, state_in;
   addr_type  addr_ff, addr_in;
   id_type    carry_ff, carry_in;
   id_type    id_ff, id_in;

   addr_type  last_addr;
   addr_type  addr_step;
   logic      at_last;
   logic      at_zero;

   logic      we;
   addr_type  wa;
   id_type    wd;
   addr_type  ra;
   id_type    rd;

   rrq_ram #(
      .WIDTH (ID_W),
      .DEPTH (MAX_MEMBERS)
   ) u_cells (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (wa),
      .wr_data (wd),
      .rd_addr (ra),
      .rd_data (rd)
   );

   // count never exceeds capacity, so the last index fits the address
   assign last_addr = AW'(count - id_type'(1));
   assign at_last   = (addr_ff == last_addr);
   assign at_zero   = (addr_ff == '0);
   // one address stepper: down for the serve pass, up otherwise
   assign addr_step = (state_ff == ST_SERVE) ? addr_ff - addr_type'(1)
                                             : addr_ff + addr_type'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
         addr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
      end
      carry_ff <= carry_in;
      id_ff    <= id_in;
   end

   always_comb begin
      state_in       = state_ff;
      addr_in        = addr_ff;
      carry_in       = carry_ff;
      id_in          = id_ff;
      we             = 1'b0;
      wa             = addr_ff;
      wd             = carry_ff;
      ra             = addr_ff;
      stat.req_ready = 1'b0;
      stat.push      = 1'b0;
      stat.data      = carry_ff;

      unique case (state_ff)
         ST_FILL: begin
            we = 1'b1;
            wd = id_type'(addr_ff) + id_type'(1);
            if (at_last) begin
               addr_in  = '0;
               state_in = ST_IDLE;
            end else begin
               addr_in = addr_step;
            end
         end
         ST_IDLE: begin
            // keep the front cell in flight for the next serve
            ra             = '0;
            stat.req_ready = 1'b1;
            if (req_valid) begin
               if (req_opcode == OP_SERVE) begin
                  state_in = ST_FRONT;
               end else if (req_member_id != '0 && req_member_id <= count) begin
                  id_in    = req_member_id;
                  carry_in = req_member_id;
                  addr_in  = '0;
                  state_in = ST_EXPED;
               end
            end
         end
         ST_FRONT: begin
            carry_in = rd;
            addr_in  = last_addr;
            ra       = last_addr;
            state_in = ST_SERVE;
         end
         ST_SERVE: begin
            // drop the carry in, lift the old cell out
            we       = 1'b1;
            carry_in = rd;
            if (at_zero) begin
               state_in = ST_EMIT;
            end else begin
               addr_in = addr_step;
               ra      = addr_step;
            end
         end
         ST_EXPED: begin
            we       = 1'b1;
            carry_in = rd;
            if (rd == id_ff || at_last) begin
               addr_in  = '0;
               state_in = ST_IDLE;
            end else begin
               addr_in = addr_step;
               ra      = addr_step;
            end
         end
         ST_EMIT: begin
            // carry holds the old front after the backward pass
            if (slot_free) begin
               stat.push = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_FILL;
            addr_in  = '0;
         end
      endcase

      if (reload) begin
         state_in = ST_FILL;
         addr_in  = '0;
      end
   end

endmodule
